### design/strict_base64_decoder_macros.svh
// Assertion macros used by the decoder module.
`ifndef STRICT_BASE64_DECODER_MACROS_SVH
`define STRICT_BASE64_DECODER_MACROS_SVH

// Checks that the condition holds in the same cycle as the trigger.
`define SB64_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Checks that the condition holds in the cycle after the trigger.
`define SB64_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

### design/sb64_pkg.sv
package sb64_pkg;

  // Field widths.
  localparam int CHAR_W  = 8;
  localparam int SEXT_W  = 6;
  localparam int COUNT_W = 16;
  localparam int REG_W   = 16;
  localparam int INDEX_W = 1;

  // Register indexes on the write port.
  localparam logic [INDEX_W-1:0] REG_MAX_CHARS = 1'b0;
  localparam logic [INDEX_W-1:0] REG_MAX_BYTES = 1'b1;

  // Register reset values.
  localparam logic [REG_W-1:0] RESET_MAX_CHARS = 16'd21848;
  localparam logic [REG_W-1:0] RESET_MAX_BYTES = 16'd16384;

  // Pad character and saturation value of the character counter.
  localparam logic [CHAR_W-1:0]  PAD_CHAR  = 8'h3D;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Position of a character within its quad.
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2,
    POS_FOURTH = 2'd3
  } quad_pos_t;

  // Decoded character: sextet and whether it is in the alphabet.
  typedef struct packed {
    logic              valid;
    logic [SEXT_W-1:0] value;
  } sextet_t;

  // Maps one ASCII code to its sextet; codes outside the alphabet give zero.
  function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] ch);
    sextet_t s;
    s.valid = 1'b1;
    s.value = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      s.value = SEXT_W'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s.value = SEXT_W'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.value = SEXT_W'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      s.value = 6'd62;
    end else if (ch == 8'h2F) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

### design/sb64_if.sv
// Character channel into the decoder.
interface sb64_text_if;
  logic                       valid;
  logic                       ready;
  logic [sb64_pkg::CHAR_W-1:0] character;
  logic                       text_last;

  modport source (output valid, output character, output text_last, input ready);
  modport sink (input valid, input character, input text_last, output ready);
endinterface

// Result channel out of the decoder.
interface sb64_result_if;
  logic                        valid;
  logic                        ready;
  logic [sb64_pkg::CHAR_W-1:0]  data_byte;
  logic                        data_valid;
  logic                        text_end;
  logic                        status;
  logic [sb64_pkg::COUNT_W-1:0] total_bytes;

  modport source (output valid, output data_byte, output data_valid, output text_end,
                  output status, output total_bytes, input ready);
  modport sink (input valid, input data_byte, input data_valid, input text_end,
                input status, input total_bytes, output ready);
endinterface

### design/strict_base64_decoder.sv
// Channel    Role     Payload
// text       sink     character[7:0], text_last
// decoded    source   data_byte[7:0], data_valid, text_end, status, total_bytes[15:0]
// wr_*       write    wr_en, wr_index[0:0], wr_data[15:0]
//
// One character per cycle unless stalled; input register feeds the result register.
// The decode step is a table lookup plus two 16-bit increments and limit compares.
// Reset restores both limit registers and clears the per-text state at once.
// A stall on decoded fills the result register and then the input register before
// text.ready falls.

`include "strict_base64_decoder_macros.svh"

module strict_base64_decoder (
  input  logic                          clk,
  input  logic                          rst,
  sb64_text_if.sink                     text,
  sb64_result_if.source                 decoded,
  input  logic                          wr_en,
  input  logic [sb64_pkg::INDEX_W-1:0]  wr_index,
  input  logic [sb64_pkg::REG_W-1:0]    wr_data
);

  // Limit registers.
  logic [sb64_pkg::REG_W-1:0] max_chars;
  logic [sb64_pkg::REG_W-1:0] max_bytes;

  // Input register.
  logic                         in_valid;
  logic [sb64_pkg::CHAR_W-1:0]  in_char;
  logic                         in_last;

  // Per-text state.
  sb64_pkg::quad_pos_t           quad_position, quad_position_next;
  logic [sb64_pkg::SEXT_W-1:0]  held_sextet, held_sextet_next;
  logic                         pad_seen, pad_seen_next;
  logic [sb64_pkg::COUNT_W-1:0] char_count, char_count_next;
  logic [sb64_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic                         error_flag, error_flag_next;

  // Result register contents.
  logic                         out_valid;
  logic [sb64_pkg::CHAR_W-1:0]  out_byte, out_byte_next;
  logic                         out_dvalid, out_dvalid_next;
  logic                         out_end;
  logic                         out_status;
  logic [sb64_pkg::COUNT_W-1:0] out_total;

  logic             out_free;
  logic             advance;
  logic             is_pad;
  logic             have_byte;
  sb64_pkg::sextet_t sx;

  // Handshake: the result register frees when empty or taken, the input register
  // moves on when the result register can take its item.
  assign out_free   = !out_valid || decoded.ready;
  assign advance    = in_valid && out_free;
  assign text.ready = !in_valid || out_free;

  assign decoded.valid       = out_valid;
  assign decoded.data_byte   = out_byte;
  assign decoded.data_valid  = out_dvalid;
  assign decoded.text_end    = out_end;
  assign decoded.status      = out_status;
  assign decoded.total_bytes = out_total;

  // Limit register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= sb64_pkg::RESET_MAX_CHARS;
      max_bytes <= sb64_pkg::RESET_MAX_BYTES;
    end else if (wr_en) begin
      case (wr_index)
        sb64_pkg::REG_MAX_CHARS: max_chars <= wr_data;
        sb64_pkg::REG_MAX_BYTES: max_bytes <= wr_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      in_char <= text.character;
      in_last <= text.text_last;
    end
  end

  // Decode step for the character in the input register.
  always_comb begin
    logic [sb64_pkg::CHAR_W-1:0] byte_val;
    logic                        err;
    sx       = sb64_pkg::sextet_of(in_char);
    is_pad   = (in_char == sb64_pkg::PAD_CHAR);
    byte_val = '0;
    have_byte = 1'b0;
    pad_seen_next = pad_seen;

    char_count_next = (char_count == sb64_pkg::COUNT_MAX) ? char_count
                                                           : char_count + 1'b1;
    err = error_flag || (char_count_next > max_chars);

    case (quad_position)
      sb64_pkg::POS_FIRST: begin
        if (!sx.valid) err = 1'b1;
        pad_seen_next = 1'b0;
      end
      sb64_pkg::POS_SECOND: begin
        if (!sx.valid) err = 1'b1;
        have_byte = 1'b1;
        byte_val  = {held_sextet, sx.value[5:4]};
      end
      sb64_pkg::POS_THIRD: begin
        if (is_pad) begin
          pad_seen_next = 1'b1;
          if (held_sextet[3:0] != 4'd0) err = 1'b1;
        end else begin
          if (!sx.valid) err = 1'b1;
          have_byte = 1'b1;
          byte_val  = {held_sextet[3:0], sx.value[5:2]};
        end
      end
      default: begin
        if (is_pad) begin
          if (!in_last) err = 1'b1;
          if (!pad_seen && held_sextet[1:0] != 2'd0) err = 1'b1;
        end else begin
          if (!sx.valid || pad_seen) err = 1'b1;
          have_byte = 1'b1;
          byte_val  = {held_sextet[1:0], sx.value};
        end
      end
    endcase

    // Byte limit: an excess byte is dropped and flags the text.
    byte_count_next = byte_count;
    if (have_byte) begin
      if (byte_count >= max_bytes) begin
        err       = 1'b1;
        have_byte = 1'b0;
      end else begin
        byte_count_next = byte_count + 1'b1;
      end
    end

    if (in_last && quad_position != sb64_pkg::POS_FOURTH) err = 1'b1;

    error_flag_next    = err;
    held_sextet_next   = is_pad ? held_sextet : sx.value;
    quad_position_next = sb64_pkg::quad_pos_t'(quad_position + 2'd1);
    out_byte_next      = have_byte ? byte_val : '0;
    out_dvalid_next    = have_byte;
  end

  // Per-text state: cleared after the final character.
  always_ff @(posedge clk) begin
    if (rst) begin
      quad_position <= sb64_pkg::POS_FIRST;
      held_sextet   <= '0;
      pad_seen      <= 1'b0;
      char_count    <= '0;
      byte_count    <= '0;
      error_flag    <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        quad_position <= sb64_pkg::POS_FIRST;
        held_sextet   <= '0;
        pad_seen      <= 1'b0;
        char_count    <= '0;
        byte_count    <= '0;
        error_flag    <= 1'b0;
      end else begin
        quad_position <= quad_position_next;
        held_sextet   <= held_sextet_next;
        pad_seen      <= pad_seen_next;
        char_count    <= char_count_next;
        byte_count    <= byte_count_next;
        error_flag    <= error_flag_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= out_byte_next;
      out_dvalid <= out_dvalid_next;
      out_end    <= in_last;
      out_status <= error_flag_next;
      out_total  <= byte_count_next;
    end
  end

  // Checks.
  `SB64_ASSERT_SAME(a_byte_zero_when_absent, out_valid && !out_dvalid, out_byte == '0,
    "decoded byte is not zero on a result without a byte")
  `SB64_ASSERT_SAME(a_byte_counted, out_valid && out_dvalid, out_total != '0,
    "result carries a byte but the byte total is zero")
  `SB64_ASSERT_NEXT(a_text_cleared, advance && in_last,
    quad_position == sb64_pkg::POS_FIRST && byte_count == '0 && !error_flag,
    "per-text state not cleared after the final character")
  `SB64_ASSERT_SAME(a_stall_full, !text.ready, in_valid && out_valid,
    "input held off while a register is still free")
  `SB64_ASSERT_SAME(a_no_byte_first, advance && quad_position == sb64_pkg::POS_FIRST,
    !out_dvalid_next, "byte produced on the first character of a quad")

endmodule
